/* sv/fir_filter_11_tap_fixed_point_assert.svh */
// Assertion macros for the FIR filter block.
// No dependencies; define SYNTH to compile the checks out.
`ifndef FIR_FILTER_11_TAP_FIXED_POINT_ASSERT_SVH
`define FIR_FILTER_11_TAP_FIXED_POINT_ASSERT_SVH
`ifndef SYNTH
`define FIR11_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define FIR11_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define FIR11_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define FIR11_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* sv/fir11_pkg.sv */
// Shared constants and coefficient lookup for the 11-tap FIR filter.
// No dependencies.
package fir11_pkg;

   localparam int TAP_COUNT_DEF    = 11;
   localparam int SAMPLE_BITS_DEF  = 13;
   localparam int APPROX_SHIFT_DEF = 0;

   localparam int OUT_BITS   = 14;
   localparam int COEF_BITS  = 12;
   localparam int COEF_COUNT = 11;
   localparam int COEF_IDX_W = $clog2(COEF_COUNT);

   localparam logic signed [COEF_BITS-1:0] COEF_TABLE [COEF_COUNT] = '{
      -12'sd1, -12'sd52, -12'sd102, 12'sd260, 12'sd1125, 12'sd1630,
      12'sd1125, 12'sd260, -12'sd102, -12'sd52, -12'sd1
   };

   // taps past the table carry a zero coefficient
   function automatic logic signed [COEF_BITS-1:0] coef_at(input int idx);
      logic signed [COEF_BITS-1:0] c;
      c = '0;
      if (idx < COEF_COUNT) begin
         c = COEF_TABLE[COEF_IDX_W'(idx)];
      end
      return c;
   endfunction

endpackage

/* sv/fir11_if.sv */
// Valid/ready stream interfaces for the FIR filter sample channels.
// No dependencies.
interface fir11_req_if #(parameter int SAMPLE_BITS = 13);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface fir11_rsp_if #(parameter int OUT_BITS = 14);
   logic                       valid;
   logic                       ready;
   logic signed [OUT_BITS-1:0] sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

/* sv/fir_filter_11_tap_fixed_point.sv */
// Channel  Dir  Payload                     Handshake
// req_if   in   sample_in  (SAMPLE_BITS, s) valid/ready
// rsp_if   out  sample_out (14, s)          valid/ready
//
// One sample per clock; the result of a sample is offered the cycle after its beat.
// Throughput is set by the cell chain: every cell does one constant multiply and
// one add per accepted beat, with the sample broadcast to all cells.
// Cell 0's partial sum register is the output register, so a stalled rsp side
// holds the whole chain and blocks req until the pending beat is taken.
// Synchronous reset clears the partial sums (empty history) and the output valid.
`include "fir_filter_11_tap_fixed_point_assert.svh"
module fir_filter_11_tap_fixed_point import fir11_pkg::*; #(
   parameter int TAP_COUNT    = TAP_COUNT_DEF,
   parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
   parameter int APPROX_SHIFT = APPROX_SHIFT_DEF
) (
   input logic         clock,
   input logic         reset,
   fir11_req_if.sink   req_if,
   fir11_rsp_if.source rsp_if
);

   localparam int ACC_W       = SAMPLE_BITS + COEF_BITS + $clog2(TAP_COUNT);
   localparam int FINAL_SHIFT = SAMPLE_BITS - 1 - 2 * APPROX_SHIFT;
   localparam int SHR         = (FINAL_SHIFT > 0) ? FINAL_SHIFT : 0;
   localparam int SHL         = (FINAL_SHIFT < 0) ? -FINAL_SHIFT : 0;
   localparam int EXT_W       = ACC_W + OUT_BITS;

   logic                          advance;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] x_shifted;
   logic signed [ACC_W-1:0]       psum [TAP_COUNT+1];
   logic signed [EXT_W-1:0]       sum_ext;
   logic signed [EXT_W-1:0]       sum_scaled;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign advance      = req_if.valid && req_if.ready;
   assign x_shifted    = req_if.sample_in >>> APPROX_SHIFT;

   // end of chain feeds zero into the last cell
   assign psum[TAP_COUNT] = '0;

   for (genvar k = 0; k < TAP_COUNT; k++) begin : g_cell
      fir11_cell #(
         .TAP_INDEX    (k),
         .SAMPLE_BITS  (SAMPLE_BITS),
         .APPROX_SHIFT (APPROX_SHIFT),
         .ACC_W        (ACC_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .x         (x_shifted),
         .psum_next (psum[k+1]),
         .psum      (psum[k])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // final scaling is constant shifts and truncation only
   assign sum_ext           = $signed({{OUT_BITS{psum[0][ACC_W-1]}}, psum[0]});
   assign sum_scaled        = (sum_ext >>> SHR) <<< SHL;
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.sample_out = sum_scaled[OUT_BITS-1:0];

   `FIR11_ASSERT_NEXT(a_beat_gives_result, clock, reset,
      advance, rsp_valid_ff, "accepted beat did not produce a result")
   `FIR11_ASSERT_IMP(a_stall_blocks_req, clock, reset,
      rsp_valid_ff && !rsp_if.ready, !req_if.ready, "req ready while result is stalled")
   `FIR11_ASSERT_NEXT(a_chain_holds, clock, reset,
      !advance, $stable(psum[0]), "output sum moved without a beat")

endmodule

/* sv/fir11_cell.sv */
// One transposed-form FIR cell: constant multiply plus partial sum register.
// Depends on fir11_pkg.
module fir11_cell import fir11_pkg::*; #(
   parameter int TAP_INDEX    = 0,
   parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
   parameter int APPROX_SHIFT = APPROX_SHIFT_DEF,
   parameter int ACC_W        = SAMPLE_BITS_DEF + COEF_BITS + 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic signed [SAMPLE_BITS-1:0] x,
   input  logic signed [ACC_W-1:0]       psum_next,
   output logic signed [ACC_W-1:0]       psum
);

   localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
   localparam logic signed [COEF_BITS-1:0] COEF = coef_at(TAP_INDEX) >>> APPROX_SHIFT;

   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0]  psum_in;
   logic signed [ACC_W-1:0]  psum_ff;

   assign prod    = x * COEF;
   assign psum_in = $signed({{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod}) + psum_next;
   assign psum    = psum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         psum_ff <= '0;
      end else if (advance) begin
         psum_ff <= psum_in;
      end
   end

endmodule

/* test/fir11_sample_checker.sv */
// Scoreboard for the 11-tap FIR filter: predicts each filtered sample from the
// accepted input beats and compares it with the result channel.
// Depends on fir11_pkg for the sample and output widths, tap count and approximation shift.
module fir11_sample_checker import fir11_pkg::*; (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic signed [SAMPLE_BITS_DEF-1:0] req_sample,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic signed [OUT_BITS-1:0]        rsp_sample,
   output int                                fail_count,
   output int                                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HIST_DEPTH = TAP_COUNT_DEF - 1;
   localparam int NORM_SHIFT = SAMPLE_BITS_DEF - 1 - 2 * APPROX_SHIFT_DEF;
   localparam int TAP_WEIGHT [TAP_COUNT_DEF] = '{
      -1, -52, -102, 260, 1125, 1630, 1125, 260, -102, -52, -1
   };

   logic signed [SAMPLE_BITS_DEF-1:0] history [HIST_DEPTH];
   logic signed [OUT_BITS-1:0]        expected_out [$];
   int                                errors = 0;

   // newest sample sits at tap 0; the sum is exact, then floored by NORM_SHIFT
   function automatic logic signed [OUT_BITS-1:0] filter_step(
      input logic signed [SAMPLE_BITS_DEF-1:0] x);
      int acc;
      acc = (int'(x) >>> APPROX_SHIFT_DEF) * (TAP_WEIGHT[0] >>> APPROX_SHIFT_DEF);
      for (int i = 0; i < HIST_DEPTH; i++) begin
         acc += (int'(history[i]) >>> APPROX_SHIFT_DEF)
              * (TAP_WEIGHT[i + 1] >>> APPROX_SHIFT_DEF);
      end
      for (int i = HIST_DEPTH - 1; i > 0; i--) begin
         history[i] = history[i - 1];
      end
      history[0] = x;
      return OUT_BITS'(acc >>> NORM_SHIFT);
   endfunction

   always @(posedge clock) begin
      logic signed [OUT_BITS-1:0] want;
      if (reset) begin
         foreach (history[i]) history[i] = '0;
         expected_out.delete();
      end else begin
         if (req_valid && req_ready) begin
            expected_out.push_back(filter_step(req_sample));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_out.size() == 0) begin
               $error("sample_out: beat with nothing expected, actual %0d", rsp_sample);
               errors++;
            end else begin
               want = expected_out.pop_front();
               if (rsp_sample !== want) begin
                  $error("sample_out mismatch: expected %0d, actual %0d", want, rsp_sample);
                  errors++;
               end
            end
         end
      end
      fail_count <= errors;
      pending    <= expected_out.size();
   end

endmodule

/* test/fir_filter_11_tap_fixed_point_tb.sv */
// Top of the FIR filter testbench: clock, reset, sample stimulus, result-side
// stalls, watchdog and verdict. Depends on fir11_pkg, the stream interfaces,
// the filter block and fir11_sample_checker.
module fir_filter_11_tap_fixed_point_tb import fir11_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_SAMPLES = 1400;
   localparam int STALL_PCT      = 19;
   localparam int IDLE_LIMIT     = 2000;
   localparam logic signed [SAMPLE_BITS_DEF-1:0] SAMPLE_MAX = 13'sd4095;
   localparam logic signed [SAMPLE_BITS_DEF-1:0] SAMPLE_MIN = -13'sd4096;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic calm  = 1'b0;   // no idling on either side while set
   int   samples_sent = 0;
   int   results_seen = 0;
   int   idle_cycles  = 0;
   int   out_low      = 0;
   int   out_high     = 0;
   int   fail_count;
   int   pending;

   fir11_req_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) req ();
   fir11_rsp_if #(.OUT_BITS(OUT_BITS))           rsp ();

   fir_filter_11_tap_fixed_point DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp)
   );

   fir11_sample_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_ready  (req.ready),
      .req_sample (req.sample_in),
      .rsp_valid  (rsp.valid),
      .rsp_ready  (rsp.ready),
      .rsp_sample (rsp.sample_out),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= STALL_PCT);
   end

   // watchdog on cycles without any beat; also tracks the output range
   always @(posedge clock) begin
      if (rsp.valid && rsp.ready && !reset) begin
         results_seen <= results_seen + 1;
         if (rsp.sample_out < out_low) out_low <= rsp.sample_out;
         if (rsp.sample_out > out_high) out_high <= rsp.sample_out;
      end
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
         $display("fir_filter_11_tap_fixed_point_tb NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic push_sample(input logic signed [SAMPLE_BITS_DEF-1:0] s);
      while (!calm && $urandom_range(0, 99) < STALL_PCT) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid     <= 1'b1;
      req.sample_in <= s;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      samples_sent++;
   endtask

   task automatic drain_results();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // mix of full-range noise, extremes, small values, single-bit patterns
   // and constant runs so the filter settles at its DC gain
   function automatic logic signed [SAMPLE_BITS_DEF-1:0] pick_sample(
      input logic signed [SAMPLE_BITS_DEF-1:0] prev);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 35) return SAMPLE_BITS_DEF'($urandom());
      if (roll < 50) begin
         case ($urandom_range(0, 4))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return -13'sd1;
            3:       return 13'sd1;
            default: return '0;
         endcase
      end
      if (roll < 70) return SAMPLE_BITS_DEF'($urandom_range(0, 32)) - 13'sd16;
      if (roll < 82) begin
         if ($urandom_range(0, 1) != 0) return 13'sd1 <<< $urandom_range(0, 12);
         return ~(13'sd1 <<< $urandom_range(0, 12));
      end
      return prev;
   endfunction

   initial begin
      logic signed [SAMPLE_BITS_DEF-1:0] last;
      req.valid     = 1'b0;
      req.sample_in = '0;
      rsp.ready     = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // smallest step each way: +1 and -1 samples, then zero, exercise the floor near zero
      push_sample(13'sd1);
      push_sample(-13'sd1);
      push_sample('0);
      // signs matched to the taps, then inverted: largest and smallest outputs
      for (int k = 0; k < TAP_COUNT_DEF; k++) begin
         push_sample((k < 3 || k > 7) ? SAMPLE_MIN : SAMPLE_MAX);
      end
      for (int k = 0; k < TAP_COUNT_DEF; k++) begin
         push_sample((k < 3 || k > 7) ? SAMPLE_MAX : SAMPLE_MIN);
      end
      drain_results();

      last = '0;
      for (int n = 0; n < RANDOM_SAMPLES; n++) begin
         calm <= (n >= 600 && n < 900);
         if (n == 400 || n == 1100) drain_results();
         last = pick_sample(last);
         push_sample(last);
      end
      calm <= 1'b0;
      drain_results();
      repeat (8) @(posedge clock);

      $display("summary: %0d samples in (directed extremes, noise, runs, bit patterns),",
               samples_sent);
      $display("         %0d filtered samples checked, output range %0d .. %0d",
               results_seen, out_low, out_high);
      if (fail_count == 0 && pending == 0) begin
         $display("fir_filter_11_tap_fixed_point_tb OK");
      end else begin
         $display("fir_filter_11_tap_fixed_point_tb NOT OK");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+sv
sv/fir11_pkg.sv
sv/fir11_if.sv
sv/fir11_cell.sv
sv/fir_filter_11_tap_fixed_point.sv
test/fir11_sample_checker.sv
test/fir_filter_11_tap_fixed_point_tb.sv
